/* design/ccbm_pkg.sv */
package ccbm_pkg;

    typedef enum logic [1:0] {
        ACT_ALLOC  = 2'd0,
        ACT_FREE   = 2'd1,
        ACT_LOCATE = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_REFUSED = 2'd1,
        ST_BEYOND  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CFG_NODE_COUNT  = 2'd0,
        CFG_CHUNK_COUNT = 2'd1,
        CFG_CHUNK_BYTES = 2'd2
    } t_cfg_index;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_A_RD,
        S_A_WALK,
        S_A_TAIL,
        S_A_DONE,
        S_F_RD,
        S_F_WALK,
        S_F_DONE,
        S_L_RD,
        S_L_CHK,
        S_L_WALK,
        S_L_DONE,
        S_OUT
    } t_state;

endpackage

/* design/chunk_chain_buffer_manager.sv */
// a request refused up front or with an unknown action goes straight to S_OUT; allocate time grows
//   with need, free with chain length, locate with links walked (no walk past the node end)
// the chunk link memory walk and a 23-step bit-serial divider set the time
// one request at a time; start is taken only when busy is low, from the cycle after o_done
// reset and each write to a defined configuration index run a clearing pass over all node and chunk entries
// the receiver cannot stall: each result shows for one cycle with o_done
module chunk_chain_buffer_manager #(
    parameter int MAX_NODES       = 256,
    parameter int MAX_CHUNKS      = 1024,
    parameter int MAX_CHUNK_BYTES = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [12:0] i_cfg_data,
    input  logic [1:0]  i_action,
    input  logic [7:0]  i_node,
    input  logic [22:0] i_size_bytes,
    input  logic [21:0] i_byte_offset,
    output logic        o_done,
    output logic [1:0]  o_status,
    output logic [7:0]  o_node_out,
    output logic [9:0]  o_chunk_number,
    output logic [9:0]  o_chunk_index,
    output logic [12:0] o_bytes_left,
    output logic [22:0] o_node_bytes,
    output logic [8:0]  o_free_nodes,
    output logic [10:0] o_free_chunks,
    output logic [22:0] o_free_room
);

    localparam int NW  = $clog2(MAX_NODES);
    localparam int CW  = $clog2(MAX_CHUNKS);
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int CCW = $clog2(MAX_CHUNKS + 1);
    localparam int BW  = $clog2(MAX_CHUNK_BYTES + 1);
    localparam int CLW = (NW > CW) ? NW : CW;
    localparam int CLR_LAST = ((MAX_NODES > MAX_CHUNKS) ? MAX_NODES : MAX_CHUNKS) - 1;
    // link word: msb set means no link
    localparam int LW  = ((NW > CW) ? NW : CW) + 1;

    // memories
    logic [LW-1:0] r_chunk_mem [MAX_CHUNKS];
    logic [LW-1:0] r_link_mem  [MAX_NODES];
    logic [22:0]   r_size_mem  [MAX_NODES];
    logic          r_busy_mem  [MAX_NODES];

    logic [CW-1:0] chunk_raddr, chunk_waddr;
    logic          chunk_we;
    logic [LW-1:0] chunk_wdata, r_chunk_rdata;
    logic [NW-1:0] node_raddr, node_waddr;
    logic          node_we;
    logic [LW-1:0] link_wdata, r_link_rdata;
    logic [22:0]   size_wdata, r_size_rdata;
    logic          busy_wdata, r_busy_rdata;

    always_ff @(posedge i_clk) begin
        if (chunk_we) begin
            r_chunk_mem[chunk_waddr] <= chunk_wdata;
        end
        r_chunk_rdata <= r_chunk_mem[chunk_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (node_we) begin
            r_link_mem[node_waddr] <= link_wdata;
            r_size_mem[node_waddr] <= size_wdata;
            r_busy_mem[node_waddr] <= busy_wdata;
        end
        r_link_rdata <= r_link_mem[node_raddr];
        r_size_rdata <= r_size_mem[node_raddr];
        r_busy_rdata <= r_busy_mem[node_raddr];
    end

    ccbm_pkg::t_state r_state, n_state;

    logic [NCW-1:0] r_node_count, n_node_count;
    logic [CCW-1:0] r_chunk_count, n_chunk_count;
    logic [BW-1:0]  r_chunk_bytes, n_chunk_bytes;
    logic [LW-1:0]  r_free_node_head, n_free_node_head;
    logic [LW-1:0]  r_free_chunk_head, n_free_chunk_head;
    logic [NCW-1:0] r_usable_nodes, n_usable_nodes;
    logic [CCW-1:0] r_usable_chunks, n_usable_chunks;
    logic [CLW-1:0] r_clr, n_clr;

    logic [1:0]     r_action, n_action;
    logic [7:0]     r_node, n_node;
    logic [22:0]    r_size, n_size;
    logic [21:0]    r_off, n_off;
    // divider: dividend shifts out, quotient shifts in
    logic [22:0]    r_dq, n_dq;
    logic [BW-1:0]  r_rem, n_rem;
    logic [4:0]     r_cnt, n_cnt;
    logic [22:0]    r_quo, n_quo;
    logic [LW-1:0]  r_idx, n_idx;
    logic [CCW-1:0] r_k, n_k;
    logic [22:0]    r_need, n_need;
    logic [22:0]    r_s, n_s;

    logic           r_done, n_done;
    logic [1:0]     r_status, n_status;
    logic [7:0]     r_node_out, n_node_out;
    logic [9:0]     r_cno, n_cno;
    logic [9:0]     r_cidx, n_cidx;
    logic [12:0]    r_left, n_left;
    logic [22:0]    r_nbytes, n_nbytes;
    logic [22:0]    r_room, n_room;

    // room needs one multiply; registered and refreshed every cycle
    logic [CCW+BW-1:0] room_full;
    assign room_full = r_usable_chunks * r_chunk_bytes;
    always_comb begin
        n_room = (room_full > (CCW+BW)'(23'h7FFFFF)) ? 23'h7FFFFF : 23'(room_full);
    end
    logic [CCW+BW-1:0] r_room_full;
    always_ff @(posedge i_clk) begin
        r_room_full <= room_full;
    end

    // divider step
    logic [BW:0]   div_trial;
    logic          div_ge;
    assign div_trial = {r_rem, r_dq[22]};
    assign div_ge    = div_trial >= {1'b0, r_chunk_bytes};

    function automatic logic [12:0] cfg_clamp(input logic [12:0] v, input int hi);
        logic [12:0] r;
        begin
            if (v == 13'd0) r = 13'd1;
            else if (32'(v) > hi) r = 13'(hi);
            else r = v;
            cfg_clamp = r;
        end
    endfunction

    always_comb begin
        n_state          = r_state;
        n_node_count     = r_node_count;
        n_chunk_count    = r_chunk_count;
        n_chunk_bytes    = r_chunk_bytes;
        n_free_node_head = r_free_node_head;
        n_free_chunk_head = r_free_chunk_head;
        n_usable_nodes   = r_usable_nodes;
        n_usable_chunks  = r_usable_chunks;
        n_clr            = r_clr;
        n_action         = r_action;
        n_node           = r_node;
        n_size           = r_size;
        n_off            = r_off;
        n_dq             = r_dq;
        n_rem            = r_rem;
        n_cnt            = r_cnt;
        n_quo            = r_quo;
        n_idx            = r_idx;
        n_k              = r_k;
        n_need           = r_need;
        n_s              = r_s;
        n_done           = 1'b0;
        n_status         = r_status;
        n_node_out       = r_node_out;
        n_cno            = r_cno;
        n_cidx           = r_cidx;
        n_left           = r_left;
        n_nbytes         = r_nbytes;
        chunk_raddr      = r_idx[CW-1:0];
        chunk_waddr      = r_idx[CW-1:0];
        chunk_we         = 1'b0;
        chunk_wdata      = '0;
        node_raddr       = r_node[NW-1:0];
        node_waddr       = r_node[NW-1:0];
        node_we          = 1'b0;
        link_wdata       = '0;
        size_wdata       = '0;
        busy_wdata       = 1'b0;

        case (r_state)
            ccbm_pkg::S_CLEAR: begin
                if (32'(r_clr) < MAX_CHUNKS) begin
                    chunk_we    = 1'b1;
                    chunk_waddr = r_clr[CW-1:0];
                    chunk_wdata = (32'(r_clr) + 1 < 32'(r_chunk_count)) ?
                                  LW'(r_clr) + LW'(1) : {1'b1, {(LW-1){1'b0}}};
                end
                if (32'(r_clr) < MAX_NODES) begin
                    node_we    = 1'b1;
                    node_waddr = r_clr[NW-1:0];
                    link_wdata = (32'(r_clr) + 1 < 32'(r_node_count)) ?
                                 LW'(r_clr) + LW'(1) : {1'b1, {(LW-1){1'b0}}};
                end
                n_clr = r_clr + CLW'(1);
                if (32'(r_clr) == CLR_LAST) begin
                    n_state = ccbm_pkg::S_IDLE;
                end
            end
            ccbm_pkg::S_IDLE: begin
                // busy stays high while the last result shows
                if (start && !r_done) begin
                    n_action = i_action;
                    n_node   = i_node;
                    n_size   = i_size_bytes;
                    n_off    = i_byte_offset;
                    n_status = ccbm_pkg::ST_OK;
                    n_node_out = '0;
                    n_cno    = '0;
                    n_cidx   = '0;
                    n_left   = '0;
                    n_nbytes = '0;
                    n_rem    = '0;
                    n_cnt    = '0;
                    n_quo    = '0;
                    n_dq     = (i_action == ccbm_pkg::ACT_LOCATE) ? {1'b0, i_byte_offset}
                                                                 : i_size_bytes;
                    case (ccbm_pkg::t_action'(i_action))
                        ccbm_pkg::ACT_ALLOC: begin
                            if (r_usable_nodes != '0 && r_usable_chunks != '0 &&
                                r_room_full > (CCW+BW)'(i_size_bytes) &&
                                !r_free_node_head[LW-1] && !r_free_chunk_head[LW-1]) begin
                                n_state = ccbm_pkg::S_DIV;
                            end else begin
                                n_status = ccbm_pkg::ST_REFUSED;
                                n_state  = ccbm_pkg::S_OUT;
                            end
                        end
                        ccbm_pkg::ACT_FREE:   n_state = ccbm_pkg::S_F_RD;
                        ccbm_pkg::ACT_LOCATE: n_state = ccbm_pkg::S_L_RD;
                        default:              n_state = ccbm_pkg::S_OUT;
                    endcase
                end
            end
            ccbm_pkg::S_DIV: begin
                n_dq  = {r_dq[21:0], 1'b0};
                n_rem = div_ge ? BW'(div_trial - {1'b0, r_chunk_bytes}) : BW'(div_trial);
                n_quo = {r_quo[21:0], div_ge};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd22) begin
                    if (r_action == ccbm_pkg::ACT_ALLOC) begin
                        n_state = ccbm_pkg::S_A_RD;
                    end else begin
                        n_state = ccbm_pkg::S_L_CHK;
                    end
                end
            end
            ccbm_pkg::S_A_RD: begin
                // need = ceil(size / chunk), at least one
                n_need = (r_rem != '0 || r_quo == '0) ? r_quo + 23'd1 : r_quo;
                n_idx  = r_free_chunk_head;
                n_k    = CCW'(1);
                chunk_raddr = r_free_chunk_head[CW-1:0];
                n_state = ccbm_pkg::S_A_WALK;
            end
            ccbm_pkg::S_A_WALK: begin
                // r_chunk_rdata holds next of r_idx
                if (r_need > 23'(r_usable_chunks)) begin
                    n_status = ccbm_pkg::ST_REFUSED;
                    n_state  = ccbm_pkg::S_OUT;
                end else if (23'(r_k) >= r_need) begin
                    node_raddr = r_free_node_head[NW-1:0];
                    n_state = ccbm_pkg::S_A_TAIL;
                end else if (r_chunk_rdata[LW-1]) begin
                    n_status = ccbm_pkg::ST_REFUSED;
                    n_state  = ccbm_pkg::S_OUT;
                end else begin
                    n_idx = r_chunk_rdata;
                    n_k   = r_k + CCW'(1);
                    chunk_raddr = r_chunk_rdata[CW-1:0];
                    n_state = ccbm_pkg::S_A_DONE;
                end
            end
            ccbm_pkg::S_A_DONE: begin
                // wait for the registered read, then continue walking
                n_state = ccbm_pkg::S_A_WALK;
            end
            ccbm_pkg::S_A_TAIL: begin
                // r_link_rdata is link of the free node head; r_chunk_rdata is next of tail
                node_we    = 1'b1;
                node_waddr = r_free_node_head[NW-1:0];
                link_wdata = r_free_chunk_head;
                size_wdata = r_size;
                busy_wdata = 1'b1;
                chunk_we    = 1'b1;
                chunk_waddr = r_idx[CW-1:0];
                chunk_wdata = {1'b1, {(LW-1){1'b0}}};
                n_free_node_head  = r_link_rdata;
                n_free_chunk_head = r_chunk_rdata;
                n_usable_nodes    = r_usable_nodes - NCW'(1);
                n_usable_chunks   = r_usable_chunks - CCW'(r_need);
                n_node_out = 8'(r_free_node_head);
                n_nbytes   = r_size;
                n_state    = ccbm_pkg::S_OUT;
            end
            ccbm_pkg::S_F_RD: begin
                n_state = ccbm_pkg::S_F_WALK;
                n_k     = CCW'(1);
                n_cnt   = 5'd0;
            end
            ccbm_pkg::S_F_WALK: begin
                if (32'(r_node) >= MAX_NODES || !r_busy_rdata) begin
                    n_state = ccbm_pkg::S_OUT;
                end else if (r_cnt == 5'd0) begin
                    // first visit: start at the head of the node chain
                    n_s    = r_size_rdata;
                    n_need = 23'(r_link_rdata);
                    n_idx  = r_link_rdata;
                    chunk_raddr = r_link_rdata[CW-1:0];
                    n_cnt  = 5'd1;
                    n_state = ccbm_pkg::S_F_DONE;
                end else if (32'(r_k) < MAX_CHUNKS && !r_idx[LW-1] &&
                             !r_chunk_rdata[LW-1]) begin
                    n_idx = r_chunk_rdata;
                    n_k   = r_k + CCW'(1);
                    chunk_raddr = r_chunk_rdata[CW-1:0];
                    n_state = ccbm_pkg::S_F_DONE;
                end else begin
                    if (!r_idx[LW-1]) begin
                        chunk_we    = 1'b1;
                        chunk_waddr = r_idx[CW-1:0];
                        chunk_wdata = r_free_chunk_head;
                    end
                    n_free_chunk_head = LW'(r_need);
                    node_we    = 1'b1;
                    link_wdata = r_free_node_head;
                    size_wdata = '0;
                    busy_wdata = 1'b0;
                    n_nbytes   = r_s;
                    n_free_node_head = LW'(r_node);
                    n_usable_nodes   = r_usable_nodes + NCW'(1);
                    n_usable_chunks  = r_usable_chunks + r_k;
                    n_state = ccbm_pkg::S_OUT;
                end
            end
            ccbm_pkg::S_F_DONE: begin
                n_state = ccbm_pkg::S_F_WALK;
            end
            ccbm_pkg::S_L_RD: begin
                n_state = ccbm_pkg::S_DIV;
            end
            ccbm_pkg::S_L_CHK: begin
                // node reads landed during the divide; quotient is pos, remainder rem
                n_s = (32'(r_node) < MAX_NODES && r_busy_rdata) ? r_size_rdata : '0;
                n_nbytes = n_s;
                if (23'(r_off) >= n_s) begin
                    n_status = ccbm_pkg::ST_BEYOND;
                    n_state  = ccbm_pkg::S_OUT;
                end else begin
                    n_idx  = r_link_rdata;
                    n_need = r_quo;
                    n_k    = '0;
                    // size minus start of this chunk; S_L_WALK caps it by chunk_bytes and takes off rem
                    n_dq   = n_s - (23'(r_off) - 23'(r_rem));
                    chunk_raddr = r_link_rdata[CW-1:0];
                    n_state = ccbm_pkg::S_L_DONE;
                end
            end
            ccbm_pkg::S_L_DONE: begin
                n_state = ccbm_pkg::S_L_WALK;
            end
            ccbm_pkg::S_L_WALK: begin
                if (23'(r_k) >= r_need || r_idx[LW-1] || r_chunk_rdata[LW-1]) begin
                    n_cno  = 10'(r_need);
                    n_cidx = r_idx[LW-1] ? 10'd0 : 10'(r_idx);
                    n_left = (r_dq >= 23'(r_chunk_bytes)) ? 13'(r_chunk_bytes - r_rem)
                                                          : 13'(r_dq - 23'(r_rem));
                    n_state = ccbm_pkg::S_OUT;
                end else begin
                    n_idx = r_chunk_rdata;
                    n_k   = r_k + CCW'(1);
                    chunk_raddr = r_chunk_rdata[CW-1:0];
                    n_state = ccbm_pkg::S_L_DONE;
                end
            end
            ccbm_pkg::S_OUT: begin
                n_done  = 1'b1;
                n_state = ccbm_pkg::S_IDLE;
            end
            default: n_state = ccbm_pkg::S_IDLE;
        endcase

        if (i_cfg_we) begin
            case (ccbm_pkg::t_cfg_index'(i_cfg_index))
                ccbm_pkg::CFG_NODE_COUNT:
                    n_node_count = NCW'(cfg_clamp({4'd0, i_cfg_data[8:0]}, MAX_NODES));
                ccbm_pkg::CFG_CHUNK_COUNT:
                    n_chunk_count = CCW'(cfg_clamp({2'd0, i_cfg_data[10:0]}, MAX_CHUNKS));
                ccbm_pkg::CFG_CHUNK_BYTES:
                    n_chunk_bytes = BW'(cfg_clamp(i_cfg_data, MAX_CHUNK_BYTES));
                default: ;
            endcase
            if (i_cfg_index <= ccbm_pkg::CFG_CHUNK_BYTES) begin
                n_state           = ccbm_pkg::S_CLEAR;
                n_clr             = '0;
                n_free_node_head  = '0;
                n_free_chunk_head = '0;
                n_usable_nodes    = n_node_count;
                n_usable_chunks   = n_chunk_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state           <= ccbm_pkg::S_CLEAR;
            r_clr             <= '0;
            r_node_count      <= NCW'(MAX_NODES < 256 ? MAX_NODES : 256);
            r_chunk_count     <= CCW'(MAX_CHUNKS < 1024 ? MAX_CHUNKS : 1024);
            r_chunk_bytes     <= BW'(MAX_CHUNK_BYTES < 64 ? MAX_CHUNK_BYTES : 64);
            r_free_node_head  <= '0;
            r_free_chunk_head <= '0;
            r_usable_nodes    <= NCW'(MAX_NODES < 256 ? MAX_NODES : 256);
            r_usable_chunks   <= CCW'(MAX_CHUNKS < 1024 ? MAX_CHUNKS : 1024);
            r_done            <= 1'b0;
        end else begin
            r_state           <= n_state;
            r_clr             <= n_clr;
            r_node_count      <= n_node_count;
            r_chunk_count     <= n_chunk_count;
            r_chunk_bytes     <= n_chunk_bytes;
            r_free_node_head  <= n_free_node_head;
            r_free_chunk_head <= n_free_chunk_head;
            r_usable_nodes    <= n_usable_nodes;
            r_usable_chunks   <= n_usable_chunks;
            r_done            <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action   <= n_action;
        r_node     <= n_node;
        r_size     <= n_size;
        r_off      <= n_off;
        r_dq       <= n_dq;
        r_rem      <= n_rem;
        r_cnt      <= n_cnt;
        r_quo      <= n_quo;
        r_idx      <= n_idx;
        r_k        <= n_k;
        r_need     <= n_need;
        r_s        <= n_s;
        r_status   <= n_status;
        r_node_out <= n_node_out;
        r_cno      <= n_cno;
        r_cidx     <= n_cidx;
        r_left     <= n_left;
        r_nbytes   <= n_nbytes;
        r_room     <= n_room;
    end

    assign busy           = (r_state != ccbm_pkg::S_IDLE) || r_done;
    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_node_out     = r_node_out;
    assign o_chunk_number = r_cno;
    assign o_chunk_index  = r_cidx;
    assign o_bytes_left   = r_left;
    assign o_node_bytes   = r_nbytes;
    assign o_free_nodes   = 9'(r_usable_nodes);
    assign o_free_chunks  = 11'(r_usable_chunks);
    assign o_free_room    = r_room;

endmodule

/* design/ccbm_checker.sv */
module ccbm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_done,
    input logic [1:0]  o_status,
    input logic [8:0]  o_free_nodes,
    input logic [10:0] o_free_chunks
);

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("done held two cycles");

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result while idle");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_status <= 2'(ccbm_pkg::ST_BEYOND)))
        else $error("bad status");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    a_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_free_nodes <= 9'd256 && o_free_chunks <= 11'd1024))
        else $error("free count out of range");

endmodule

bind chunk_chain_buffer_manager ccbm_checker u_ccbm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_done       (o_done),
    .o_status     (o_status),
    .o_free_nodes (o_free_nodes),
    .o_free_chunks(o_free_chunks)
);

/* dv/testbench.sv */
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES_MAX  = 256;
    localparam int CHUNKS_MAX = 1024;
    localparam int BYTES_MAX  = 4096;
    localparam int unsigned END_OF_CHAIN = 32'hFFFF_FFFF;

    typedef struct {
        ccbm_pkg::t_status status;
        logic [7:0]   node_out;
        logic [9:0]   chunk_number;
        logic [9:0]   chunk_index;
        logic [12:0]  bytes_left;
        logic [22:0]  node_bytes;
        logic [8:0]   free_nodes;
        logic [10:0]  free_chunks;
        logic [22:0]  free_room;
    } t_outcome;

    typedef struct {
        ccbm_pkg::t_action act;
        logic [7:0]   node;
        logic [22:0]  size;
        logic [21:0]  offset;
        bit           typed;
        ccbm_pkg::t_status st;
        logic [7:0]   nout;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_index = '0;
    logic [12:0] i_cfg_data = '0;
    logic [1:0]  i_action = '0;
    logic [7:0]  i_node = '0;
    logic [22:0] i_size_bytes = '0;
    logic [21:0] i_byte_offset = '0;
    logic        o_done;
    logic [1:0]  o_status;
    logic [7:0]  o_node_out;
    logic [9:0]  o_chunk_number;
    logic [9:0]  o_chunk_index;
    logic [12:0] o_bytes_left;
    logic [22:0] o_node_bytes;
    logic [8:0]  o_free_nodes;
    logic [10:0] o_free_chunks;
    logic [22:0] o_free_room;

    chunk_chain_buffer_manager dut (.*);

    always #10 i_clk = ~i_clk;

    // mirror of the pool
    int unsigned num_nodes, num_chunks, chunk_sz;
    int unsigned node_link_m [NODES_MAX];
    int unsigned node_size_m [NODES_MAX];
    bit          node_used_m [NODES_MAX];
    int unsigned chunk_link_m [CHUNKS_MAX];
    int unsigned node_head, spare_chunk_top, nodes_free, chunks_free;

    t_outcome pending_results [$];
    int errors = 0;
    int beats_in = 0, beats_out = 0, n_refused = 0, n_beyond = 0, n_cfg = 0;
    int idle_pct = 0;

    function automatic void rebuild_pool();
        for (int i = 0; i < NODES_MAX; i++) begin
            node_size_m[i] = 0;
            node_used_m[i] = 1'b0;
            node_link_m[i] = (i + 1 < num_nodes) ? i + 1 : END_OF_CHAIN;
        end
        for (int i = 0; i < CHUNKS_MAX; i++)
            chunk_link_m[i] = (i + 1 < num_chunks) ? i + 1 : END_OF_CHAIN;
        node_head = 0;
        spare_chunk_top = 0;
        nodes_free = num_nodes;
        chunks_free = num_chunks;
    endfunction

    function automatic int unsigned saturate(longint unsigned v, int unsigned hi);
        if (v < 1) return 1;
        if (v > hi) return hi;
        return int'(v);
    endfunction

    function automatic void apply_cfg(ccbm_pkg::t_cfg_index idx, logic [12:0] val);
        case (idx)
            ccbm_pkg::CFG_NODE_COUNT:  num_nodes = saturate(val[8:0], NODES_MAX);
            ccbm_pkg::CFG_CHUNK_COUNT: num_chunks = saturate(val[10:0], CHUNKS_MAX);
            ccbm_pkg::CFG_CHUNK_BYTES: chunk_sz = saturate(val, BYTES_MAX);
            default: return;
        endcase
        rebuild_pool();
    endfunction

    function automatic int unsigned link_after(int unsigned idx);
        return (idx < CHUNKS_MAX) ? chunk_link_m[idx] : END_OF_CHAIN;
    endfunction

    function automatic t_outcome predict_pool_op(ccbm_pkg::t_action act, logic [7:0] nd,
                                                 logic [22:0] sz, logic [21:0] off);
        t_outcome r;
        longint unsigned c, need, s, pos, rem, room;
        int unsigned idx, n, head, tail, cnt;
        bit ok;
        c = chunk_sz;
        r = '{ccbm_pkg::ST_OK, 0, 0, 0, 0, 0, 0, 0, 0};
        case (act)
            ccbm_pkg::ACT_ALLOC: begin
                ok = nodes_free != 0 && chunks_free != 0 && longint'(chunks_free) * c > sz
                     && node_head < NODES_MAX && spare_chunk_top < CHUNKS_MAX;
                if (ok) begin
                    need = (sz + c - 1) / c;
                    if (need == 0) need = 1;
                    idx = spare_chunk_top;
                    for (longint unsigned k = 1; k < need && idx < CHUNKS_MAX; k++)
                        idx = chunk_link_m[idx];
                    if (idx >= CHUNKS_MAX || need > chunks_free) begin
                        ok = 1'b0;
                    end else begin
                        n = node_head;
                        node_head = node_link_m[n];
                        node_link_m[n] = spare_chunk_top;
                        node_size_m[n] = sz;
                        node_used_m[n] = 1'b1;
                        spare_chunk_top = chunk_link_m[idx];
                        chunk_link_m[idx] = END_OF_CHAIN;
                        nodes_free--;
                        chunks_free -= int'(need);
                        r.node_out = 8'(n);
                        r.node_bytes = sz;
                    end
                end
                if (!ok) r.status = ccbm_pkg::ST_REFUSED;
            end
            ccbm_pkg::ACT_FREE: begin
                if (node_used_m[nd]) begin
                    head = node_link_m[nd];
                    tail = head;
                    cnt = 1;
                    while (cnt < CHUNKS_MAX && link_after(tail) != END_OF_CHAIN) begin
                        tail = chunk_link_m[tail];
                        cnt++;
                    end
                    if (tail < CHUNKS_MAX) chunk_link_m[tail] = spare_chunk_top;
                    spare_chunk_top = head;
                    r.node_bytes = 23'(node_size_m[nd]);
                    node_link_m[nd] = node_head;
                    node_size_m[nd] = 0;
                    node_used_m[nd] = 1'b0;
                    node_head = nd;
                    nodes_free++;
                    chunks_free += cnt;
                end
            end
            ccbm_pkg::ACT_LOCATE: begin
                s = node_used_m[nd] ? node_size_m[nd] : 0;
                r.node_bytes = 23'(s);
                if (off >= s) begin
                    r.status = ccbm_pkg::ST_BEYOND;
                end else begin
                    pos = off / c;
                    rem = off % c;
                    idx = node_link_m[nd];
                    if (s / c != pos) r.bytes_left = 13'(c - rem);
                    else r.bytes_left = 13'(c - rem - ((s % c) == 0 ? 0 : (c - s % c)));
                    for (longint unsigned i = 0; i < pos; i++) begin
                        if (link_after(idx) == END_OF_CHAIN) break;
                        idx = link_after(idx);
                    end
                    r.chunk_number = 10'(pos);
                    r.chunk_index = 10'((idx < CHUNKS_MAX) ? idx : 0);
                end
            end
            default: ;
        endcase
        room = longint'(chunks_free) * c;
        if (room > 23'h7FFFFF) room = 23'h7FFFFF;
        r.free_nodes = 9'(nodes_free);
        r.free_chunks = 11'(chunks_free);
        r.free_room = 23'(room);
        return r;
    endfunction

    task automatic report_mismatch(string field, longint got, longint want);
        errors++;
        $display("mismatch on %s at %0t: got %0d, want %0d", field, $realtime, got, want);
    endtask

    always @(posedge i_clk) begin
        t_outcome w;
        if (i_rst_n && o_done) begin
            beats_out++;
            if (pending_results.size() == 0) begin
                report_mismatch("result count", beats_out, beats_in);
            end else begin
                w = pending_results.pop_front();
                if (o_status !== w.status) report_mismatch("status", o_status, w.status);
                if (o_node_out !== w.node_out)
                    report_mismatch("node_out", o_node_out, w.node_out);
                if (o_chunk_number !== w.chunk_number)
                    report_mismatch("chunk_number", o_chunk_number, w.chunk_number);
                if (o_chunk_index !== w.chunk_index)
                    report_mismatch("chunk_index", o_chunk_index, w.chunk_index);
                if (o_bytes_left !== w.bytes_left)
                    report_mismatch("bytes_left", o_bytes_left, w.bytes_left);
                if (o_node_bytes !== w.node_bytes)
                    report_mismatch("node_bytes", o_node_bytes, w.node_bytes);
                if (o_free_nodes !== w.free_nodes)
                    report_mismatch("free_nodes", o_free_nodes, w.free_nodes);
                if (o_free_chunks !== w.free_chunks)
                    report_mismatch("free_chunks", o_free_chunks, w.free_chunks);
                if (o_free_room !== w.free_room)
                    report_mismatch("free_room", o_free_room, w.free_room);
            end
        end
    end

    // one request beat, with an optional random gap in front
    task automatic issue_request(t_row row);
        t_outcome w;
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start <= 1'b1;
        i_action <= row.act;
        i_node <= row.node;
        i_size_bytes <= row.size;
        i_byte_offset <= row.offset;
        do @(posedge i_clk); while (busy);
        w = predict_pool_op(row.act, row.node, row.size, row.offset);
        if (row.typed) begin
            w.status = row.st;
            w.node_out = row.nout;
        end
        if (w.status == ccbm_pkg::ST_REFUSED) n_refused++;
        if (w.status == ccbm_pkg::ST_BEYOND) n_beyond++;
        pending_results.push_back(w);
        beats_in++;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_setup(int unsigned nodes, int unsigned chunks, int unsigned bytes);
        logic [12:0] vals [3];
        vals = '{nodes, chunks, bytes};
        for (int i = 0; i < 3; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= ccbm_pkg::t_cfg_index'(i);
            i_cfg_data <= vals[i];
            @(posedge i_clk);
            i_cfg_we <= 1'b0;
            apply_cfg(ccbm_pkg::t_cfg_index'(i), vals[i]);
            n_cfg++;
            repeat (3) @(posedge i_clk);
            while (busy) @(posedge i_clk);
        end
    endtask

    function automatic t_row random_row();
        t_row r;
        int unsigned pick, nd, tries;
        r = '{ccbm_pkg::ACT_NONE, 0, 0, 0, 1'b0, ccbm_pkg::ST_OK, 0};
        r.node = $urandom;
        r.size = $urandom;
        r.offset = $urandom;
        pick = $urandom_range(99);
        if (pick < 40) begin
            r.act = ccbm_pkg::ACT_ALLOC;
            if ($urandom_range(9) != 0)
                r.size = $urandom_range(chunk_sz * $urandom_range(4));
        end else if (pick < 65) begin
            r.act = ccbm_pkg::ACT_FREE;
            if ($urandom_range(4) != 0) begin
                for (tries = 0; tries < 8; tries++) begin
                    nd = $urandom_range(num_nodes - 1);
                    if (node_used_m[nd]) break;
                end
                r.node = nd;
            end
        end else if (pick < 95) begin
            r.act = ccbm_pkg::ACT_LOCATE;
            if ($urandom_range(4) != 0) begin
                for (tries = 0; tries < 8; tries++) begin
                    nd = $urandom_range(num_nodes - 1);
                    if (node_used_m[nd]) break;
                end
                r.node = nd;
                if (node_size_m[nd] != 0 && $urandom_range(5) != 0)
                    r.offset = $urandom_range(node_size_m[nd] - 1);
                else if ($urandom_range(1) == 0)
                    r.offset = node_size_m[nd];
            end
        end
        return r;
    endfunction

    t_row directed [] = '{
        '{ccbm_pkg::ACT_ALLOC,  0, 0,      0,     1'b1, ccbm_pkg::ST_OK,      0},
        '{ccbm_pkg::ACT_ALLOC,  0, 100,    0,     1'b1, ccbm_pkg::ST_OK,      1},
        '{ccbm_pkg::ACT_LOCATE, 1, 0,      0,     1'b1, ccbm_pkg::ST_OK,      0},
        '{ccbm_pkg::ACT_LOCATE, 1, 0,      99,    1'b1, ccbm_pkg::ST_OK,      0},
        '{ccbm_pkg::ACT_LOCATE, 1, 0,      64,    1'b0, ccbm_pkg::ST_OK,      0},
        '{ccbm_pkg::ACT_LOCATE, 1, 0,      100,   1'b1, ccbm_pkg::ST_BEYOND,  0},
        '{ccbm_pkg::ACT_LOCATE, 5, 0,      0,     1'b1, ccbm_pkg::ST_BEYOND,  0},
        '{ccbm_pkg::ACT_LOCATE, 0, 0, 22'h3FFFFF, 1'b1, ccbm_pkg::ST_BEYOND,  0},
        '{ccbm_pkg::ACT_FREE,   7, 0,      0,     1'b1, ccbm_pkg::ST_OK,      0},
        '{ccbm_pkg::ACT_FREE,   255, 0,    0,     1'b1, ccbm_pkg::ST_OK,      0},
        '{ccbm_pkg::ACT_FREE,   1, 0,      0,     1'b1, ccbm_pkg::ST_OK,      0},
        '{ccbm_pkg::ACT_ALLOC,  0, 65472,  0,     1'b1, ccbm_pkg::ST_REFUSED, 0},
        '{ccbm_pkg::ACT_ALLOC,  0, 23'h7FFFFF, 0, 1'b1, ccbm_pkg::ST_REFUSED, 0},
        '{ccbm_pkg::ACT_ALLOC,  0, 65471,  0,     1'b0, ccbm_pkg::ST_OK,      0},
        '{ccbm_pkg::ACT_LOCATE, 1, 0,      65470, 1'b0, ccbm_pkg::ST_OK,      0},
        '{ccbm_pkg::ACT_ALLOC,  0, 0,      0,     1'b1, ccbm_pkg::ST_REFUSED, 0},
        '{ccbm_pkg::ACT_NONE, 255, 23'h7FFFFF, 22'h3FFFFF, 1'b1, ccbm_pkg::ST_OK, 0},
        '{ccbm_pkg::ACT_FREE,   1, 0,      0,     1'b0, ccbm_pkg::ST_OK,      0},
        '{ccbm_pkg::ACT_FREE,   0, 0,      0,     1'b0, ccbm_pkg::ST_OK,      0},
        '{ccbm_pkg::ACT_ALLOC,  0, 4095,   0,     1'b0, ccbm_pkg::ST_OK,      0}
    };

    // node, chunk and byte settings per random phase; some are out of range on purpose
    int unsigned setups [8][3] = '{
        '{256, 1024, 64},  '{1, 1, 4096},   '{16, 64, 1},     '{0, 0, 0},
        '{511, 2047, 8191}, '{3, 40, 100},  '{256, 1024, 4096}, '{200, 7, 13}
    };

    initial begin
        num_nodes = NODES_MAX;
        num_chunks = CHUNKS_MAX;
        chunk_sz = 64;
        rebuild_pool();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(posedge i_clk);
        while (busy) @(posedge i_clk);

        foreach (directed[i]) issue_request(directed[i]);
        drain_results();

        for (int ph = 0; ph < 8; ph++) begin
            write_setup(setups[ph][0], setups[ph][1], setups[ph][2]);
            idle_pct = (ph % 2 == 1) ? 66 : ((ph % 4 == 2) ? 36 : 0);
            repeat (215) issue_request(random_row());
            drain_results();
        end

        $display("%0d requests sent, %0d results checked, %0d refused, %0d past end",
                 beats_in, beats_out, n_refused, n_beyond);
        $display("%0d register writes over 8 pool setups", n_cfg);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #(400_000_000);
        $display("Verification failed");
        $finish;
    end

endmodule
